/* hw/rtl/dcrmc_pkg.sv */
`default_nettype none

package dcrmc_pkg;

    // PWM counter period; every duty is limited to min(period, 100)
    localparam int PWM_PERIOD = 100;
    localparam logic [6:0] DUTY_CAP = 7'((PWM_PERIOD < 100) ? PWM_PERIOD : 100);

    localparam logic [6:0] DUTY_FAST   = 7'd99;
    localparam logic [6:0] DUTY_NORMAL = 7'd90;
    localparam logic [6:0] DUTY_BACK   = 7'd99;
    localparam logic [6:0] DUTY_HAND   = 7'd99;

    localparam logic [6:0]  ACCEL_STEP_RST      = 7'd1;
    localparam logic [15:0] APPROACH_WINDOW_RST = 16'd50;
    localparam logic [6:0]  SLOW_DUTY_RST       = 7'd85;

    localparam int CFG_AW = 4;

    typedef enum logic [1:0] {
        REG_ACCEL_STEP      = 2'd0,
        REG_APPROACH_WINDOW = 2'd1,
        REG_SLOW_DUTY       = 2'd2
    } t_reg_idx;

    typedef enum logic [2:0] {
        REQ_TICK      = 3'd0,
        REQ_STEP_MOVE = 3'd1,
        REQ_CONST_MOVE = 3'd2,
        REQ_SOFT_STOP = 3'd3,
        REQ_HARD_STOP = 3'd4,
        REQ_ENCODER   = 3'd5
    } t_req;

    typedef enum logic [1:0] {
        DIR_IDLE = 2'd0,
        DIR_CW   = 2'd1,
        DIR_CCW  = 2'd2
    } t_dir;

    typedef enum logic [2:0] {
        LVL_STOP   = 3'd0,
        LVL_FAST   = 3'd1,
        LVL_NORMAL = 3'd2,
        LVL_SLOW   = 3'd3,
        LVL_BACK   = 3'd4,
        LVL_HAND   = 3'd5
    } t_level;

    typedef enum logic [1:0] {
        ST_STOP = 2'd0,
        ST_ACC  = 2'd1,
        ST_DEC  = 2'd2,
        ST_CON  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_SSTOP = 2'd1,
        CMD_STEP  = 2'd2
    } t_cmd;

    // last field in the lowest bits
    typedef struct packed {
        logic [15:0] step_count;
        logic [2:0]  speed_level;
        logic [1:0]  direction;
        logic [2:0]  req_type;
    } t_item;

    typedef struct packed {
        t_cmd       command_active;
        logic       pwm_enabled;
        logic       tick_enabled;
        t_status    speed_status;
        logic [6:0] pwm_ccw_compare;
        logic [6:0] pwm_cw_compare;
    } t_result;

    typedef struct packed {
        logic [6:0]  accel_step;
        logic [15:0] approach_window;
        logic [6:0]  slow_duty;
    } t_cfg;

    function automatic logic [6:0] cap_duty(input logic [6:0] d);
        cap_duty = (d > DUTY_CAP) ? DUTY_CAP : d;
    endfunction

    function automatic logic [6:0] level_duty(input logic [2:0] level,
                                              input logic [6:0] slow);
        case (level)
            LVL_FAST:   level_duty = cap_duty(DUTY_FAST);
            LVL_NORMAL: level_duty = cap_duty(DUTY_NORMAL);
            LVL_SLOW:   level_duty = cap_duty(slow);
            LVL_BACK:   level_duty = cap_duty(DUTY_BACK);
            LVL_HAND:   level_duty = cap_duty(DUTY_HAND);
            default:    level_duty = 7'd0;
        endcase
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/dc_motor_ramp_move_controller.sv */
`default_nettype none

// Two-channel PWM motor speed ramp with position stop. Each request on the
// slave stream is a ramp tick, a step move, a constant move, a soft stop, a
// hard stop or an encoder count, and produces exactly one status request on
// the master stream showing both PWM compares, the speed status, ticker and
// PWM enable, and the pending command after that request. Throughput is one
// request per clock while the master stream does not stall; a request passes
// the input register, then the state update and result register. The state
// update is one short pass: an 8-bit ramp add/compare and a 17-bit
// approach-window compare. accel_step, approach_window and slow_duty sit on
// the APB port at 0x0, 0x4 and 0x8; write them only while no request is in flight.
module dc_motor_ramp_move_controller
    import dcrmc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // slave: [2:0] req_type, [4:3] direction, [7:5] speed_level, [23:8] step_count
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [23:0]       s_axis_tdata,
    // master: [6:0] pwm_cw_compare, [13:7] pwm_ccw_compare, [15:14] speed_status,
    //         [16] tick_enabled, [17] pwm_enabled, [19:18] command_active, rest 0
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic [23:0]            m_axis_tdata,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [CFG_AW-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    t_cfg    w_cfg;
    t_result w_result;

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    logic    w_out_free;
    logic    w_step;

    dcrmc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // result register frees up when empty or being taken this cycle
    assign w_out_free    = !r_out_valid || m_axis_tready;
    // request in the input register moves through the state update
    assign w_step        = r_in_valid && w_out_free;
    assign s_axis_tready = !r_in_valid || w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in <= t_item'(s_axis_tdata);
        end
    end

    dcrmc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_step   (w_step),
        .i_item   (r_in),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_out};

endmodule

`default_nettype wire

/* hw/rtl/dcrmc_cfg.sv */
`default_nettype none

module dcrmc_cfg
    import dcrmc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [CFG_AW-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    output t_cfg                   o_cfg
);

    t_cfg r_cfg;
    logic w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.accel_step      <= ACCEL_STEP_RST;
            r_cfg.approach_window <= APPROACH_WINDOW_RST;
            r_cfg.slow_duty       <= SLOW_DUTY_RST;
        end else if (w_wr) begin
            case (paddr[3:2])
                REG_ACCEL_STEP:      r_cfg.accel_step      <= pwdata[6:0];
                REG_APPROACH_WINDOW: r_cfg.approach_window <= pwdata[15:0];
                REG_SLOW_DUTY:       r_cfg.slow_duty       <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_ACCEL_STEP:      prdata = {25'd0, r_cfg.accel_step};
            REG_APPROACH_WINDOW: prdata = {16'd0, r_cfg.approach_window};
            REG_SLOW_DUTY:       prdata = {25'd0, r_cfg.slow_duty};
            default:             prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

/* hw/rtl/dcrmc_core.sv */
`default_nettype none

module dcrmc_core
    import dcrmc_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cfg  i_cfg,
    input  wire logic  i_step,
    input  wire t_item i_item,
    output t_result    o_result
);

    logic [6:0]  r_running, n_running;
    logic [6:0]  r_target, n_target;
    t_dir        r_dir, n_dir;
    t_cmd        r_cmd, n_cmd;
    logic [15:0] r_mtarget, n_mtarget;
    logic [15:0] r_pos, n_pos;
    t_status     r_status, n_status;
    logic        r_ticking, n_ticking;
    logic        r_pwm_on, n_pwm_on;
    logic [6:0]  r_cw, n_cw;
    logic [6:0]  r_ccw, n_ccw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running <= 7'd0;
            r_target  <= 7'd0;
            r_dir     <= DIR_IDLE;
            r_cmd     <= CMD_NONE;
            r_mtarget <= 16'd0;
            r_pos     <= 16'd0;
            r_status  <= ST_STOP;
            r_ticking <= 1'b0;
            r_pwm_on  <= 1'b1;
            r_cw      <= 7'd0;
            r_ccw     <= 7'd0;
        end else if (i_step) begin
            r_running <= n_running;
            r_target  <= n_target;
            r_dir     <= n_dir;
            r_cmd     <= n_cmd;
            r_mtarget <= n_mtarget;
            r_pos     <= n_pos;
            r_status  <= n_status;
            r_ticking <= n_ticking;
            r_pwm_on  <= n_pwm_on;
            r_cw      <= n_cw;
            r_ccw     <= n_ccw;
        end
    end

    always_comb begin
        logic       v_busy;
        logic       v_drive;
        logic [7:0] v_sum;
        logic [6:0] v_gap;
        t_dir       v_dir;
        logic [6:0] v_level;

        n_running = r_running;
        n_target  = r_target;
        n_dir     = r_dir;
        n_cmd     = r_cmd;
        n_mtarget = r_mtarget;
        n_pos     = r_pos;
        n_status  = r_status;
        n_ticking = r_ticking;
        n_pwm_on  = r_pwm_on;
        n_cw      = r_cw;
        n_ccw     = r_ccw;
        v_busy    = 1'b1;
        v_drive   = 1'b0;
        v_sum     = {1'b0, r_running} + {1'b0, i_cfg.accel_step};
        v_gap     = r_running - r_target;
        // direction code three folds to idle
        v_dir     = (i_item.direction == DIR_CW || i_item.direction == DIR_CCW) ?
                    t_dir'(i_item.direction) : DIR_IDLE;
        v_level   = level_duty(i_item.speed_level, i_cfg.slow_duty);

        case (i_item.req_type)
            REQ_TICK: begin
                if (r_ticking) begin
                    // ramp, clamped at the target
                    if (r_running < r_target) begin
                        n_running = (v_sum > {1'b0, r_target}) ? r_target : v_sum[6:0];
                        v_drive   = 1'b1;
                        n_status  = ST_ACC;
                    end else if (r_running > r_target) begin
                        n_running = (i_cfg.accel_step >= v_gap) ? r_target :
                                    r_running - i_cfg.accel_step;
                        v_drive   = 1'b1;
                        n_status  = ST_DEC;
                    end else begin
                        n_status = (r_running == 7'd0) ? ST_STOP : ST_CON;
                    end

                    if (v_drive) begin
                        n_cw  = (r_dir == DIR_CW)  ? n_running : 7'd0;
                        n_ccw = (r_dir == DIR_CCW) ? n_running : 7'd0;
                    end

                    case (r_cmd)
                        CMD_NONE: v_busy = 1'b0;
                        CMD_SSTOP: begin
                            if (n_status == ST_STOP) begin
                                n_dir  = DIR_IDLE;
                                n_cmd  = CMD_NONE;
                                v_busy = 1'b0;
                            end
                        end
                        CMD_STEP: begin
                            if (r_pos >= r_mtarget) begin
                                n_ticking = 1'b0;
                                n_pwm_on  = 1'b0;
                                n_target  = 7'd0;
                                n_running = 7'd0;
                                n_status  = ST_STOP;
                                n_cw      = 7'd0;
                                n_ccw     = 7'd0;
                                n_cmd     = CMD_NONE;
                                v_busy    = 1'b0;
                            end else if (({1'b0, r_pos} + {1'b0, i_cfg.approach_window})
                                         > {1'b0, r_mtarget}) begin
                                n_target = cap_duty(i_cfg.slow_duty);
                            end
                        end
                        default: ;
                    endcase

                    if (!v_busy && (n_status == ST_STOP || n_status == ST_CON))
                        n_ticking = 1'b0;
                end
            end
            REQ_STEP_MOVE: begin
                n_dir     = v_dir;
                n_mtarget = i_item.step_count;
                n_pos     = 16'd0;
                n_target  = v_level;
                n_cmd     = CMD_STEP;
                n_pwm_on  = 1'b1;
                n_ticking = 1'b1;
            end
            REQ_CONST_MOVE: begin
                n_dir     = v_dir;
                n_target  = v_level;
                n_pwm_on  = 1'b1;
                n_ticking = 1'b1;
            end
            REQ_SOFT_STOP: begin
                n_target  = 7'd0;
                n_cmd     = CMD_SSTOP;
                n_pwm_on  = 1'b1;
                n_ticking = 1'b1;
            end
            REQ_HARD_STOP: begin
                n_ticking = 1'b0;
                n_pwm_on  = 1'b0;
                n_target  = 7'd0;
                n_running = 7'd0;
                n_status  = ST_STOP;
                n_cw      = 7'd0;
                n_ccw     = 7'd0;
            end
            REQ_ENCODER: begin
                if (r_pos != 16'hffff)
                    n_pos = r_pos + 16'd1;
            end
            default: ;
        endcase

        o_result.pwm_cw_compare  = n_cw;
        o_result.pwm_ccw_compare = n_ccw;
        o_result.speed_status    = n_status;
        o_result.tick_enabled    = n_ticking;
        o_result.pwm_enabled     = n_pwm_on;
        o_result.command_active  = n_cmd;
    end

    // duty never leaves the cap
    a_duty_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_running <= DUTY_CAP) && (r_target <= DUTY_CAP))
        else $error("running or target duty above cap");

    // at most one channel driven
    a_one_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !((r_cw != 7'd0) && (r_ccw != 7'd0)))
        else $error("both PWM channels driven");

    // a driven compare always carries the running duty
    a_compare_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_cw == 7'd0) || (r_cw == r_running)) &&
        ((r_ccw == 7'd0) || (r_ccw == r_running)))
        else $error("compare differs from running duty");

    a_hard_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_item.req_type == REQ_HARD_STOP) |=>
        (r_running == 7'd0 && !r_ticking && !r_pwm_on && r_cw == 7'd0 && r_ccw == 7'd0))
        else $error("hard stop left motor driven");

endmodule

`default_nettype wire

/* tb/tb_dc_motor_ramp_move_controller.sv */
`timescale 1ns / 100ps

module tb_dc_motor_ramp_move_controller;
    import dcrmc_pkg::*;

    // Run ceiling in clocks. About 1400 requests in all, sent partly in stalled
    // phases, plus the long hold-off, the drains and the APB writes.
    localparam int CYCLE_LIMIT = 60000;

    // Expected-status store plus a request-by-request copy of the ramp controller.
    class motor_status_scoreboard;
        int         accel_step;
        int         approach_window;
        int         slow_duty;
        int         running_duty;
        int         target_duty;
        int         move_target;
        int         position_count;
        t_dir       move_dir;
        t_cmd       pending_cmd;
        t_status    speed_status;
        bit         ticking;
        bit         outputs_on;
        logic [6:0] cw_cmp;
        logic [6:0] ccw_cmp;
        t_result    status_q[$];
        int         mismatches;

        function void reset_state();
            accel_step      = ACCEL_STEP_RST;
            approach_window = APPROACH_WINDOW_RST;
            slow_duty       = SLOW_DUTY_RST;
            running_duty    = 0;
            target_duty     = 0;
            move_target     = 0;
            position_count  = 0;
            move_dir        = DIR_IDLE;
            pending_cmd     = CMD_NONE;
            speed_status    = ST_STOP;
            ticking         = 1'b0;
            outputs_on      = 1'b1;
            cw_cmp          = '0;
            ccw_cmp         = '0;
        endfunction

        function void set_reg(t_reg_idx idx, logic [31:0] value);
            case (idx)
                REG_ACCEL_STEP:      accel_step = value[6:0];
                REG_APPROACH_WINDOW: approach_window = value[15:0];
                REG_SLOW_DUTY:       slow_duty = value[6:0];
                default: ;
            endcase
        endfunction

        function int capped(int d);
            return (d > int'(DUTY_CAP)) ? int'(DUTY_CAP) : d;
        endfunction

        function int duty_for(logic [2:0] lvl);
            case (lvl)
                LVL_FAST, LVL_BACK, LVL_HAND: return capped(99);
                LVL_NORMAL:                   return capped(90);
                LVL_SLOW:                     return capped(slow_duty);
                default:                      return 0;
            endcase
        endfunction

        function void drive_compares();
            cw_cmp  = (move_dir == DIR_CW)  ? 7'(running_duty) : 7'd0;
            ccw_cmp = (move_dir == DIR_CCW) ? 7'(running_duty) : 7'd0;
        endfunction

        function void halt_now();
            ticking      = 1'b0;
            outputs_on   = 1'b0;
            target_duty  = 0;
            running_duty = 0;
            speed_status = ST_STOP;
            cw_cmp       = '0;
            ccw_cmp      = '0;
        endfunction

        function void ramp_tick();
            bit busy;
            int gap;
            busy = 1'b1;
            if (running_duty < target_duty) begin
                running_duty = running_duty + accel_step;
                if (running_duty > target_duty) running_duty = target_duty;
                drive_compares();
                speed_status = ST_ACC;
            end else if (running_duty > target_duty) begin
                gap = running_duty - target_duty;
                running_duty = (accel_step >= gap) ? target_duty : running_duty - accel_step;
                drive_compares();
                speed_status = ST_DEC;
            end else if (running_duty == 0) begin
                speed_status = ST_STOP;
            end else begin
                speed_status = ST_CON;
            end

            case (pending_cmd)
                CMD_NONE: busy = 1'b0;
                CMD_SSTOP: begin
                    if (speed_status == ST_STOP) begin
                        move_dir    = DIR_IDLE;
                        pending_cmd = CMD_NONE;
                        busy        = 1'b0;
                    end
                end
                CMD_STEP: begin
                    if (position_count >= move_target) begin
                        halt_now();
                        pending_cmd = CMD_NONE;
                        busy        = 1'b0;
                    end else if (position_count + approach_window > move_target) begin
                        target_duty = capped(slow_duty);
                    end
                end
                default: ;
            endcase

            if (!busy && (speed_status == ST_STOP || speed_status == ST_CON))
                ticking = 1'b0;
        endfunction

        // Accepted request: advance the copy and queue the status it yields.
        function void note_request(t_item it);
            t_result exp;
            t_dir    dir;
            dir = (it.direction == 2'd3) ? DIR_IDLE : t_dir'(it.direction);
            case (it.req_type)
                REQ_TICK: if (ticking) ramp_tick();
                REQ_STEP_MOVE: begin
                    move_dir       = dir;
                    move_target    = it.step_count;
                    position_count = 0;
                    target_duty    = duty_for(it.speed_level);
                    pending_cmd    = CMD_STEP;
                    outputs_on     = 1'b1;
                    ticking        = 1'b1;
                end
                REQ_CONST_MOVE: begin
                    move_dir    = dir;
                    target_duty = duty_for(it.speed_level);
                    outputs_on  = 1'b1;
                    ticking     = 1'b1;
                end
                REQ_SOFT_STOP: begin
                    target_duty = 0;
                    pending_cmd = CMD_SSTOP;
                    outputs_on  = 1'b1;
                    ticking     = 1'b1;
                end
                REQ_HARD_STOP: halt_now();
                REQ_ENCODER: if (position_count < 65535) position_count++;
                default: ;
            endcase
            exp.pwm_cw_compare  = cw_cmp;
            exp.pwm_ccw_compare = ccw_cmp;
            exp.speed_status    = speed_status;
            exp.tick_enabled    = ticking;
            exp.pwm_enabled     = outputs_on;
            exp.command_active  = pending_cmd;
            status_q.push_back(exp);
        endfunction

        function void check_status(logic [23:0] data);
            t_result exp;
            t_result got;
            if (status_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected status request: tdata=%h", data);
                return;
            end
            exp = status_q.pop_front();
            got = t_result'(data[19:0]);
            if (got.pwm_cw_compare != exp.pwm_cw_compare
                || got.pwm_ccw_compare != exp.pwm_ccw_compare
                || got.speed_status != exp.speed_status
                || got.tick_enabled != exp.tick_enabled
                || got.pwm_enabled != exp.pwm_enabled
                || got.command_active != exp.command_active
                || data[23:20] != 4'd0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("status mismatch: cw %0d/%0d ccw %0d/%0d st %0d/%0d tick %0d/%0d pwm %0d/%0d cmd %0d/%0d pad %h (exp/got)",
                             exp.pwm_cw_compare, got.pwm_cw_compare,
                             exp.pwm_ccw_compare, got.pwm_ccw_compare,
                             exp.speed_status, got.speed_status,
                             exp.tick_enabled, got.tick_enabled,
                             exp.pwm_enabled, got.pwm_enabled,
                             exp.command_active, got.command_active, data[23:20]);
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [23:0]       s_axis_tdata;   // [2:0] req, [4:3] dir, [7:5] level, [23:8] steps
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [23:0]       m_axis_tdata;   // [6:0] cw, [13:7] ccw, [15:14] status, [16] tick,
                                       // [17] pwm on, [19:18] cmd
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    motor_status_scoreboard sb = new();

    int tx_idle_pct;    // sender gap odds, percent per clock
    int rx_idle_pct;    // receiver stall odds, percent per clock
    int rx_hold;        // forced receiver stall, clocks left
    int cycle_cnt;

    dc_motor_ramp_move_controller u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Hard ceiling on run length.
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("[dc_motor_ramp_move_controller] ERROR");
            $finish;
        end
    end

    // Receiver: forced hold-off first, otherwise random stalls. Drives at
    // the falling edge only.
    initial begin
        forever begin
            @(negedge i_clk);
            if (rx_hold > 0) begin
                m_axis_tready = 1'b0;
                rx_hold--;
            end else begin
                m_axis_tready = ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Status requests are checked at the edge that accepts them.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_status(m_axis_tdata);
    end

    function automatic t_item mk(logic [2:0] req, logic [1:0] dir, logic [2:0] lvl,
                                 logic [15:0] steps);
        t_item it;
        it.req_type    = req;
        it.direction   = dir;
        it.speed_level = lvl;
        it.step_count  = steps;
        return it;
    endfunction

    function automatic logic [1:0] rand_dir();
        int r;
        r = $urandom_range(99);
        if (r < 45) return DIR_CW;
        if (r < 90) return DIR_CCW;
        if (r < 95) return DIR_IDLE;
        return 2'd3;
    endfunction

    // mostly short moves so they finish; now and then a full-range target
    function automatic logic [15:0] rand_steps();
        if ($urandom_range(9) == 0) return 16'($urandom);
        return 16'($urandom_range(120));
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    // tvalid stays up between back-to-back requests.
    task automatic send_req(t_item it);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = it;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(it);
        @(negedge i_clk);
    endtask

    // Sender pause: drop tvalid and wait for every queued status to be checked.
    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (sb.status_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic apb_write(t_reg_idx idx, logic [31:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(idx, value);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_config(int accel, int window, int slow);
        apb_write(REG_ACCEL_STEP, accel);
        apb_write(REG_APPROACH_WINDOW, window);
        apb_write(REG_SLOW_DUTY, slow);
    endtask

    // Hand-picked requests: corner levels, directions and commands.
    task automatic directed_part();
        send_req(mk(REQ_TICK, DIR_CW, LVL_FAST, 16'd0));        // tick while idle
        send_req(mk(REQ_ENCODER, DIR_IDLE, LVL_STOP, 16'd0));
        send_req(mk(REQ_CONST_MOVE, DIR_CW, LVL_FAST, 16'd0));
        send_req(mk(REQ_TICK, DIR_IDLE, LVL_STOP, 16'd0));
        send_req(mk(REQ_TICK, DIR_IDLE, LVL_STOP, 16'd0));
        // short step move: approach window kicks in, then target reached
        send_req(mk(REQ_STEP_MOVE, DIR_CCW, LVL_HAND, 16'd3));
        send_req(mk(REQ_ENCODER, DIR_IDLE, LVL_STOP, 16'd0));
        send_req(mk(REQ_TICK, DIR_IDLE, LVL_STOP, 16'd0));
        send_req(mk(REQ_ENCODER, DIR_IDLE, LVL_STOP, 16'd0));
        send_req(mk(REQ_ENCODER, DIR_IDLE, LVL_STOP, 16'd0));
        send_req(mk(REQ_TICK, DIR_IDLE, LVL_STOP, 16'd0));
        // direction code 3 behaves as idle
        send_req(mk(REQ_CONST_MOVE, 2'd3, LVL_NORMAL, 16'd0));
        send_req(mk(REQ_TICK, DIR_IDLE, LVL_STOP, 16'd0));
        // soft stop ramps back down and clears the direction
        send_req(mk(REQ_CONST_MOVE, DIR_CW, LVL_BACK, 16'd0));
        send_req(mk(REQ_TICK, DIR_IDLE, LVL_STOP, 16'd0));
        send_req(mk(REQ_SOFT_STOP, DIR_CCW, LVL_FAST, 16'hffff));
        repeat (3) send_req(mk(REQ_TICK, DIR_IDLE, LVL_STOP, 16'd0));
        send_req(mk(REQ_HARD_STOP, DIR_CCW, LVL_HAND, 16'hffff));
        // unused request codes and levels
        send_req(mk(3'd6, DIR_CW, LVL_FAST, 16'h1234));
        send_req(mk(3'd7, 2'd3, 3'd7, 16'hffff));
        send_req(mk(REQ_CONST_MOVE, DIR_CCW, 3'd6, 16'd0));
        send_req(mk(REQ_CONST_MOVE, DIR_CCW, 3'd7, 16'd0));
        send_req(mk(REQ_TICK, DIR_IDLE, LVL_STOP, 16'd0));
        send_req(mk(REQ_STEP_MOVE, DIR_CW, LVL_SLOW, 16'hffff));
        send_req(mk(REQ_TICK, DIR_IDLE, LVL_STOP, 16'd0));
        send_req(mk(REQ_HARD_STOP, DIR_IDLE, LVL_STOP, 16'd0));
        drain();

        // zero ramp step: duty never moves; slow duty above the cap
        set_config(0, 50, 127);
        send_req(mk(REQ_CONST_MOVE, DIR_CW, LVL_SLOW, 16'd0));
        repeat (2) send_req(mk(REQ_TICK, DIR_IDLE, LVL_STOP, 16'd0));
        send_req(mk(REQ_HARD_STOP, DIR_IDLE, LVL_STOP, 16'd0));
        drain();

        // big step: ramps to 99, then clamps at the capped slow duty of 100
        apb_write(REG_ACCEL_STEP, 99);
        send_req(mk(REQ_CONST_MOVE, DIR_CW, LVL_SLOW, 16'd0));
        repeat (2) send_req(mk(REQ_TICK, DIR_IDLE, LVL_STOP, 16'd0));
        send_req(mk(REQ_STEP_MOVE, DIR_CCW, LVL_FAST, 16'd0));
    endtask

    // Random traffic: mostly a move command followed by a burst of mostly ticks and
    // encoder counts with random content, plus some fully random noise.
    task automatic random_traffic(int n_items);
        int    sent;
        int    r;
        int    body;
        t_item it;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(99);
            if (r < 8) begin
                it = t_item'(24'($urandom));
                send_req(it);
                if (it.req_type <= REQ_ENCODER) sent++;
            end else begin
                it = mk(($urandom_range(9) < 6) ? REQ_STEP_MOVE : REQ_CONST_MOVE,
                        rand_dir(), 3'($urandom_range(7)), rand_steps());
                send_req(it);
                sent++;
                body = $urandom_range(10, 160);
                if (body > n_items - sent) body = n_items - sent;
                repeat (body) begin
                    r = $urandom_range(99);
                    if (r < 55)
                        it = mk(REQ_TICK, 2'($urandom), 3'($urandom), 16'($urandom));
                    else if (r < 88)
                        it = mk(REQ_ENCODER, 2'($urandom), 3'($urandom), 16'($urandom));
                    else if (r < 92)
                        it = mk(REQ_SOFT_STOP, 2'($urandom), 3'($urandom), 16'($urandom));
                    else if (r < 95)
                        it = mk(REQ_HARD_STOP, 2'($urandom), 3'($urandom), 16'($urandom));
                    else if (r < 98)
                        it = mk(REQ_CONST_MOVE, rand_dir(), 3'($urandom_range(7)),
                                16'($urandom));
                    else
                        it = mk(REQ_STEP_MOVE, rand_dir(), 3'($urandom_range(7)),
                                rand_steps());
                    send_req(it);
                    sent++;
                end
            end
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        tx_idle_pct   = 0;
        rx_idle_pct   = 0;
        rx_hold       = 0;
        cycle_cnt     = 0;
        sb.reset_state();

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        directed_part();
        drain();

        // phase 1: sender mostly busy, receiver mostly stalled
        set_config(7, 20, 40);
        tx_idle_pct = 27;
        rx_idle_pct = 78;
        random_traffic(225);
        rx_hold = 150;              // long back-pressure while the sender keeps going
        random_traffic(225);
        drain();

        // phase 2: roles swapped; top-of-range settings
        set_config(99, 65535, 100);
        tx_idle_pct = 78;
        rx_idle_pct = 27;
        random_traffic(225);
        drain();                    // sender waits for every status
        random_traffic(225);
        drain();

        // phase 3: no idling; bottom-of-range settings
        set_config(1, 0, 0);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_traffic(450);
        drain();
        repeat (10) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.status_q.size() == 0) begin
            $display("[dc_motor_ramp_move_controller] OK");
        end else begin
            $display("[dc_motor_ramp_move_controller] ERROR");
        end
        $finish;
    end

endmodule

/* dc_motor_ramp_move_controller.f */
hw/rtl/dcrmc_pkg.sv
hw/rtl/dcrmc_cfg.sv
hw/rtl/dcrmc_core.sv
hw/rtl/dc_motor_ramp_move_controller.sv
tb/tb_dc_motor_ramp_move_controller.sv
